FILE: sv/arff_pkg.sv
// ----------------------------------------------------------------------------
// arff_pkg: shared types and constants for the adaptive resampling frame FIFO
// Holds the defaults, register indexes, controller states and the command and
// status bundles that connect the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package arff_pkg;

  // Default sizes
  localparam int unsigned CAPACITY_FRAMES_DEF = 32768;
  localparam int unsigned MAX_POP_FRAMES_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF     = 24;

  // Fixed field widths
  localparam int PHASE_W    = 40;   // Q12.28 read phase
  localparam int FRAC_W     = 28;
  localparam int RATIO_W    = 32;   // Q4.28 ratio
  localparam int TARGET_W   = 16;
  localparam int REQ_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DVS_W      = 24;   // divisor width, holds 250 * 65535

  // Register reset values
  localparam logic [RATIO_W-1:0]  BASE_RATIO_RST   = 32'h1000_0000;
  localparam logic [TARGET_W-1:0] TARGET_FILL_RST  = 16'd576;
  localparam logic [TARGET_W-1:0] STARTUP_FILL_RST = 16'd192;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RATIO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FILL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_FILL = 2'd2;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Rate correction constants: gain 0.004 = 1/250, clamp 0.01 = 1/100
  localparam int DROP_MARGIN = 1024;
  localparam int CORR_DIV    = 250;
  localparam int CORR_HALF   = 125;
  localparam int CLAMP_DIV   = 100;
  localparam int CLAMP_HALF  = 50;
  localparam int CLAMP_NUM   = 5;   // clamp when 2*|d| > 5*t

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CORR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RATIO,
    ST_TEST,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_EMIT,
    ST_CONSUME,
    ST_INVALID
  } state_t;

  typedef struct packed {
    logic push;
    logic latch;
    logic arm;
    logic drop;
    logic corr;
    logic div_start;
    logic ratio;
    logic rd1;
    logic mul;
    logic emit;
    logic consume;
    logic invalid;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic armed;
    logic below_start;
    logic below_two;
    logic can_read;
    logic div_busy;
    logic out_free;
    logic last_f;
    logic none_produced;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/arff_div.sv
// ----------------------------------------------------------------------------
// arff_div: iterative restoring divider
// One quotient bit per cycle; busy drops once the last quotient bit is in.
// ----------------------------------------------------------------------------
`default_nettype none

module arff_div import arff_pkg::*; #(
  parameter int DVD_W = 49
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // shift in next dividend bit and try a subtract
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

FILE: sv/arff_dp.sv
// ----------------------------------------------------------------------------
// arff_dp: frame ring, rate correction and interpolation datapath
// Holds the frame memory, pointers, fill, phase, config registers, the ratio
// divider and the output register. Driven by commands from arff_ctrl.
// ----------------------------------------------------------------------------
`default_nettype none

module arff_dp import arff_pkg::*; #(
  parameter int unsigned CAPACITY_FRAMES = CAPACITY_FRAMES_DEF,
  parameter int unsigned MAX_POP_FRAMES  = MAX_POP_FRAMES_DEF,
  parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [SAMPLE_BITS-1:0] left_in,
  input  wire logic [SAMPLE_BITS-1:0] right_in,
  input  wire logic [REQ_W-1:0]       frames_requested,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  output logic                        over_drop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SAMPLE_BITS-1:0]      left_out,
  output logic [SAMPLE_BITS-1:0]      right_out,
  output logic                        frame_valid,
  output logic                        last
);

  localparam int SB    = SAMPLE_BITS;
  localparam int PW    = (CAPACITY_FRAMES > 1) ? $clog2(CAPACITY_FRAMES) : 1;
  localparam int FW    = $clog2(CAPACITY_FRAMES + 1);
  localparam int NW    = $clog2(MAX_POP_FRAMES + 1);
  localparam int IW    = PHASE_W - FRAC_W;
  localparam int DW_D  = (FW > TARGET_W) ? FW : TARGET_W;
  localparam int KW    = (FW > IW) ? FW : IW;
  localparam int AW    = ((PW > DW_D) ? PW : DW_D) + 1;
  localparam int HW    = (FW > TARGET_W + 2) ? FW : TARGET_W + 2;
  localparam int MW    = RATIO_W + DW_D;
  localparam int DVD_W = MW + 1;
  localparam int PRODW = SB + FRAC_W + 2;

  // config registers
  logic [RATIO_W-1:0]  base_ratio;
  logic [TARGET_W-1:0] target_fill;
  logic [TARGET_W-1:0] startup_fill;

  // ring state
  logic [PW-1:0]      read_pointer;
  logic [PW-1:0]      write_pointer;
  logic [FW-1:0]      fill_count;
  logic [PHASE_W-1:0] phase;
  logic               reader_armed;

  // per-pop working registers
  logic [NW-1:0]       n_req;
  logic [NW-1:0]       produced;
  logic [MW-1:0]       prod;
  logic                neg_r;
  logic                clamp_r;
  logic [TARGET_W-1:0] teff_r;
  logic [RATIO_W-1:0]  ratio;
  logic [PHASE_W-1:0]  phase_adv;
  logic                last_f;
  logic [2*SB-1:0]     rd_data;
  logic [2*SB-1:0]     s0;
  logic signed [PRODW-1:0] prod_l;
  logic signed [PRODW-1:0] prod_r;

  logic [2*SB-1:0] mem [CAPACITY_FRAMES];

  // combinational helpers
  logic [DW_D-1:0]     fill_x;
  logic [DW_D-1:0]     tgt_x;
  logic [TARGET_W-1:0] teff;
  logic [DW_D-1:0]     teff_x;
  logic                neg;
  logic [DW_D-1:0]     dev;
  logic                clamp;
  logic [HW-1:0]       hard;
  logic [HW-1:0]       hard4;
  logic [HW-1:0]       hardm;
  logic [IW-1:0]       i0;
  logic [IW-1:0]       i0_adv;
  logic [PW-1:0]       p0;
  logic [PW-1:0]       p1;
  logic [PW-1:0]       rd_addr;
  logic [KW-1:0]       k;
  logic [DVD_W-1:0]    dividend;
  logic [DVS_W-1:0]    divisor;
  logic [DVD_W-1:0]    quotient;
  logic [DVD_W:0]      ratio_sum;
  logic [DW_D-1:0]     drop;
  logic [PW-1:0]       wp_expect;
  logic [NW-1:0]       n_sat;
  logic                div_busy;
  logic                out_free;
  logic signed [SB:0]      diff_l;
  logic signed [SB:0]      diff_r;
  logic signed [FRAC_W:0]  frac_s;
  logic signed [PRODW-1:0] rnd_l;
  logic signed [PRODW-1:0] rnd_r;
  logic [SB-1:0]           res_l;
  logic [SB-1:0]           res_r;

  // ring index plus offset, offset below capacity
  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p,
                                             input logic [AW-1:0] x);
    logic [AW-1:0] s;
    s = AW'(p) + x;
    if (s >= AW'(CAPACITY_FRAMES)) s = s - AW'(CAPACITY_FRAMES);
    return s[PW-1:0];
  endfunction

  // config write transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      base_ratio   <= BASE_RATIO_RST;
      target_fill  <= TARGET_FILL_RST;
      startup_fill <= STARTUP_FILL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_RATIO:   base_ratio   <= cfg_data;
        REG_TARGET_FILL:  target_fill  <= cfg_data[TARGET_W-1:0];
        REG_STARTUP_FILL: startup_fill <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // fill comparisons and correction terms
  always_comb begin
    fill_x = DW_D'(fill_count);
    tgt_x  = DW_D'(target_fill);
    teff   = (target_fill == '0) ? TARGET_W'(1) : target_fill;
    teff_x = DW_D'(teff);
    neg    = fill_x < teff_x;
    dev    = neg ? (teff_x - fill_x) : (fill_x - teff_x);
    clamp  = (DW_D + 3)'({dev, 1'b0}) > ((DW_D + 3)'(teff_x) * (DW_D + 3)'(CLAMP_NUM));
    hard4  = HW'({target_fill, 2'b00});
    hardm  = HW'(target_fill) + HW'(DROP_MARGIN);
    hard   = (hardm > hard4) ? hardm : hard4;
    drop   = fill_x - tgt_x;
    n_sat  = (frames_requested > REQ_W'(MAX_POP_FRAMES)) ? NW'(MAX_POP_FRAMES)
                                                          : NW'(frames_requested);
  end

  // read addressing
  always_comb begin
    i0      = phase[PHASE_W-1:FRAC_W];
    i0_adv  = phase_adv[PHASE_W-1:FRAC_W];
    p0      = ring_add(read_pointer, AW'(i0));
    p1      = (p0 == PW'(CAPACITY_FRAMES - 1)) ? '0 : p0 + PW'(1);
    rd_addr = cmd.rd1 ? p1 : p0;
    k       = ((KW)'(i0) > (KW)'(fill_count)) ? (KW)'(fill_count) : (KW)'(i0);
    wp_expect = ring_add(read_pointer, AW'(fill_count));
  end

  // divider operands
  always_comb begin
    if (clamp_r) begin
      dividend = DVD_W'(base_ratio) + DVD_W'(CLAMP_HALF);
      divisor  = DVS_W'(CLAMP_DIV);
    end else begin
      dividend = DVD_W'(prod) + DVD_W'(teff_r) * DVD_W'(CORR_HALF);
      divisor  = DVS_W'(teff_r) * DVS_W'(CORR_DIV);
    end
    ratio_sum = (DVD_W + 1)'(base_ratio) + (DVD_W + 1)'(quotient);
  end

  arff_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // frame memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) mem[write_pointer] <= {left_in, right_in};
    rd_data <= mem[rd_addr];
  end

  // ring pointers, fill, phase, arm flag
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
      phase         <= '0;
      reader_armed  <= 1'b0;
    end else begin
      if (cmd.push) begin
        write_pointer <= ring_add(write_pointer, AW'(1));
        if (fill_count == FW'(CAPACITY_FRAMES)) begin
          read_pointer <= ring_add(read_pointer, AW'(1));
          phase        <= '0;
        end else begin
          fill_count <= fill_count + FW'(1);
        end
      end
      if (cmd.arm) reader_armed <= 1'b1;
      if (cmd.drop) begin
        read_pointer <= ring_add(read_pointer, AW'(drop));
        fill_count   <= FW'(target_fill);
        phase        <= '0;
      end
      if (cmd.emit) phase <= phase_adv;
      if (cmd.consume) begin
        read_pointer <= ring_add(read_pointer, AW'(k));
        fill_count   <= fill_count - FW'(k);
        phase        <= phase - (PHASE_W'(k) << FRAC_W);
      end
    end
  end

  // per-pop working registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      n_req    <= n_sat;
      produced <= '0;
    end
    if (cmd.corr) begin
      prod    <= MW'(base_ratio) * MW'(dev);
      neg_r   <= neg;
      clamp_r <= clamp;
      teff_r  <= teff;
    end
    if (cmd.ratio) begin
      if (neg_r) begin
        ratio <= (quotient > DVD_W'(base_ratio)) ? '1 : base_ratio - quotient[RATIO_W-1:0];
      end else begin
        ratio <= (ratio_sum > (DVD_W + 1)'({RATIO_W{1'b1}})) ? '1 : ratio_sum[RATIO_W-1:0];
      end
    end
    if (cmd.rd1) begin
      s0        <= rd_data;
      phase_adv <= phase + PHASE_W'(ratio);
    end
    if (cmd.mul) begin
      prod_l <= diff_l * frac_s;
      prod_r <= diff_r * frac_s;
      last_f <= ((produced + NW'(1)) == n_req) ||
                (((KW + 1)'(i0_adv) + (KW + 1)'(1)) >= (KW + 1)'(fill_count));
    end
    if (cmd.emit) produced <= produced + NW'(1);
  end

  // interpolation: s0 + round((s1 - s0) * frac)
  always_comb begin
    diff_l = $signed({rd_data[2*SB-1], rd_data[2*SB-1:SB]}) -
             $signed({s0[2*SB-1], s0[2*SB-1:SB]});
    diff_r = $signed({rd_data[SB-1], rd_data[SB-1:0]}) -
             $signed({s0[SB-1], s0[SB-1:0]});
    frac_s = $signed({1'b0, phase[FRAC_W-1:0]});
    rnd_l  = (prod_l + $signed(PRODW'(1) << (FRAC_W - 1))) >>> FRAC_W;
    rnd_r  = (prod_r + $signed(PRODW'(1) << (FRAC_W - 1))) >>> FRAC_W;
    res_l  = s0[2*SB-1:SB] + rnd_l[SB-1:0];
    res_r  = s0[SB-1:0] + rnd_r[SB-1:0];
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.invalid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      left_out    <= res_l;
      right_out   <= res_r;
      frame_valid <= 1'b1;
      last        <= last_f;
    end else if (cmd.invalid) begin
      left_out    <= '0;
      right_out   <= '0;
      frame_valid <= 1'b0;
      last        <= 1'b1;
    end
  end

  // status to controller
  always_comb begin
    sts.n_zero        = n_req == '0;
    sts.armed         = reader_armed;
    sts.below_start   = fill_x < DW_D'(startup_fill);
    sts.below_two     = fill_count < FW'(2);
    sts.can_read      = ((KW + 1)'(i0) + (KW + 1)'(1)) < (KW + 1)'(fill_count);
    sts.div_busy      = div_busy;
    sts.out_free      = out_free;
    sts.last_f        = last_f;
    sts.none_produced = produced == '0;
  end

  // drop decision goes to the controller, which issues the drop command
  logic over_hard;
  assign over_hard = HW'(fill_count) > hard;
  assign over_drop = over_hard;

  // checks
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(CAPACITY_FRAMES))
    else $error("fill above capacity");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    wp_expect == write_pointer)
    else $error("pointers disagree with fill");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.invalid) |-> !(out_valid && out_stall))
    else $error("result overwrote a waiting transaction");

  a_drop_to_target: assert property (@(posedge clk) disable iff (rst)
    (cmd.drop && over_hard) |=> (fill_count == $past(FW'(target_fill))) && (phase == '0))
    else $error("drop did not settle at target");

endmodule

`default_nettype wire

FILE: sv/arff_ctrl.sv
// ----------------------------------------------------------------------------
// arff_ctrl: pop sequencer
// Accepts pushes in idle, walks a pop through arm/drop checks, ratio
// correction, per-frame reads and interpolation, then phase consumption.
// ----------------------------------------------------------------------------
`default_nettype none

module arff_ctrl import arff_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic operation,
  output logic      in_stall,
  input  wire sts_t sts,
  input  wire logic over_drop,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   go_on;

  // pop passes the arm check
  assign go_on = !sts.n_zero && (sts.armed || !sts.below_start);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid && operation == OP_POP) state_next = ST_CHECK;
      ST_CHECK: begin
        if (!go_on || sts.below_two) state_next = ST_INVALID;
        else                         state_next = ST_CORR;
      end
      ST_CORR:     state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (!sts.div_busy) state_next = ST_RATIO;
      ST_RATIO:    state_next = ST_TEST;
      ST_TEST:     state_next = sts.can_read ? ST_RD0 : ST_CONSUME;
      ST_RD0:      state_next = ST_RD1;
      ST_RD1:      state_next = ST_MUL;
      ST_MUL:      state_next = ST_EMIT;
      ST_EMIT:     if (sts.out_free) state_next = sts.last_f ? ST_CONSUME : ST_RD0;
      ST_CONSUME:  state_next = sts.none_produced ? ST_INVALID : ST_IDLE;
      ST_INVALID:  if (sts.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.push  = in_valid && operation == OP_PUSH;
        cmd.latch = in_valid && operation == OP_POP;
      end
      ST_CHECK: begin
        cmd.arm  = go_on;
        cmd.drop = go_on && !sts.below_two && over_drop;
      end
      ST_CORR:    cmd.corr = 1'b1;
      ST_DIV_GO:  cmd.div_start = 1'b1;
      ST_RATIO:   cmd.ratio = 1'b1;
      ST_RD1:     cmd.rd1 = 1'b1;
      ST_MUL:     cmd.mul = 1'b1;
      ST_EMIT:    cmd.emit = sts.out_free;
      ST_CONSUME: cmd.consume = 1'b1;
      ST_INVALID: cmd.invalid = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/adaptive_resampling_frame_fifo.sv
// ----------------------------------------------------------------------------
// adaptive_resampling_frame_fifo: stereo frame FIFO with rate-corrected
// linear-interpolation reader
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in_valid / in_stall   | operation, left_in, right_in,
//           |                       | frames_requested
//   out     | out_valid / out_stall | left_out, right_out, frame_valid, last
//
// A push is taken in the idle state. A pop passes the check, correction and
// divider-start states and waits on the ratio divider (one quotient bit per
// cycle); each output frame then takes two reads of the one frame read port,
// the multiply stage and emit, and a consume state retires whole phase steps.
// Reset clears pointers, fill, phase and the arm flag; the frame memory is
// not cleared. A stalled output holds the sequencer in place; a finished
// result waiting in the output register does not block the next push.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_resampling_frame_fifo import arff_pkg::*; #(
  parameter int unsigned CAPACITY_FRAMES = CAPACITY_FRAMES_DEF,
  parameter int unsigned MAX_POP_FRAMES  = MAX_POP_FRAMES_DEF,
  parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   operation,
  input  wire logic [SAMPLE_BITS-1:0] left_in,
  input  wire logic [SAMPLE_BITS-1:0] right_in,
  input  wire logic [REQ_W-1:0]       frames_requested,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SAMPLE_BITS-1:0]      left_out,
  output logic [SAMPLE_BITS-1:0]      right_out,
  output logic                        frame_valid,
  output logic                        last
);

  cmd_t cmd;
  sts_t sts;
  logic over_drop;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  arff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .sts       (sts),
    .over_drop (over_drop),
    .cmd       (cmd)
  );

  arff_dp #(
    .CAPACITY_FRAMES (CAPACITY_FRAMES),
    .MAX_POP_FRAMES  (MAX_POP_FRAMES),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .left_in          (left_in),
    .right_in         (right_in),
    .frames_requested (frames_requested),
    .cmd              (cmd),
    .sts              (sts),
    .over_drop        (over_drop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .left_out         (left_out),
    .right_out        (right_out),
    .frame_valid      (frame_valid),
    .last             (last)
  );

endmodule

`default_nettype wire
